>>> hw/rtl/omd_pkg.sv
// omd_pkg: constants shared by the obstacle map dilation block
// register indexes, reset values and fixed field widths; no dependencies
package omd_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxRadiusDef = 16;
  localparam int unsigned MaxHeight    = 4096;

  localparam int unsigned RowW       = 12;
  localparam int unsigned HeightValW = 13;
  localparam int unsigned PixW       = 32;

  localparam int unsigned CfgWidthW  = 11;
  localparam int unsigned CfgHeightW = 13;
  localparam int unsigned CfgRadiusW = 5;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] RegMapWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMapHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRadius    = 2'd2;

  localparam int unsigned ResetWidth  = 640;
  localparam int unsigned ResetHeight = 480;
  localparam int unsigned ResetRadius = 3;

endpackage

>>> hw/rtl/obstacle_map_dilation.sv
// obstacle_map_dilation: binary dilation of a raster rgba map by a square window
// depends on omd_pkg; holds the per-column obstacle row memory and the pixel delay memory
//
// Pixels enter in raster order, one transfer per clock; a pixel with red, green and
// blue all zero is an obstacle. Each output cell is marked (black, alpha kept) when an
// obstacle lies in rows k-r+1..k+r and columns m-r+1..m+r, clipped at the map edges.
// The block sustains one item per cycle unless the output stalls; a result passes
// stages 1 and 2 and the output register, and results begin once radius*map_width+radius
// items have been taken. After the last pixel, flush items (or further pixels, whose
// bytes are dropped) drain the tail; the final cell carries tlast. Geometry is latched
// at the first pixel of a frame. A stall on the output stops the input in the same cycle.
// The pixel delay memory holds (MAX_WIDTH+1)*(MAX_RADIUS+1) words; the obstacle row
// memory holds one entry per column and is rewritten along the first row of each frame,
// so neither needs a clearing pass.
module obstacle_map_dilation import omd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_RADIUS = MaxRadiusDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PixW-1:0]     s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
  input  logic                s_axis_tuser,   // action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [PixW-1:0]     m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
  output logic                m_axis_tuser,   // marked
  output logic                m_axis_tlast    // last
);

  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned SRW   = 2 * MAX_RADIUS;
  localparam int unsigned TRW   = RowW + 1;
  localparam int unsigned DW    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int unsigned Depth = (MAX_WIDTH + 1) * (MAX_RADIUS + 1);
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned EW    = WW + RW + 1;
  localparam int unsigned LW    = RowW + 1;

  // configuration
  logic [CfgWidthW-1:0]  cfg_w_q;
  logic [CfgHeightW-1:0] cfg_h_q;
  logic [CfgRadiusW-1:0] cfg_r_q;
  logic [WW-1:0]         w_cfg;
  logic [HeightValW-1:0] h_cfg;
  logic [RW-1:0]         r_cfg;
  logic [DW-1:0]         del_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CfgWidthW'(ResetWidth);
      cfg_h_q <= CfgHeightW'(ResetHeight);
      cfg_r_q <= CfgRadiusW'(ResetRadius);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMapWidth:  cfg_w_q <= cfg_data_i[CfgWidthW-1:0];
        RegMapHeight: cfg_h_q <= cfg_data_i[CfgHeightW-1:0];
        RegRadius:    cfg_r_q <= cfg_data_i[CfgRadiusW-1:0];
        default: ;
      endcase
    end
  end

  assign w_cfg = (cfg_w_q == '0) ? WW'(1) :
                 (32'(cfg_w_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_w_q);
  assign h_cfg = (cfg_h_q == '0) ? HeightValW'(1) :
                 (32'(cfg_h_q) > MaxHeight) ? HeightValW'(MaxHeight) : cfg_h_q;
  assign r_cfg = (32'(cfg_r_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_r_q);

  assign del_c = DW'(r_cfg) * DW'(w_cfg) + DW'(r_cfg);

  // input stage
  logic                  en, acc, act, is_pix, obs;
  logic                  tick0_q, frame_rcv_q;
  logic [WW-1:0]         w_q, w_c;
  logic [HeightValW-1:0] h_q, h_c;
  logic [RW-1:0]         r_q, r_c;
  logic [CW-1:0]         tcol_q, ocol_q;
  logic [TRW-1:0]        trow_q;
  logic [RowW-1:0]       orow_q;
  logic [DW-1:0]         wait_q, wait_c;
  logic [AW-1:0]         wp_q, rp_q;
  logic                  emit0, fin0, vval0, lr_we, pxf0;
  logic [RowW-1:0]       vrow0;
  logic                  out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;
  assign act           = acc && (frame_rcv_q || !s_axis_tuser);
  assign is_pix        = acc && !s_axis_tuser && !frame_rcv_q;
  assign obs           = (s_axis_tdata[23:0] == '0);

  assign w_c    = tick0_q ? w_cfg : w_q;
  assign h_c    = tick0_q ? h_cfg : h_q;
  assign r_c    = tick0_q ? r_cfg : r_q;
  assign wait_c = tick0_q ? del_c : wait_q;

  assign emit0 = act && (wait_c == '0);
  assign fin0  = emit0 && (orow_q == RowW'(h_c - 1'b1)) && (ocol_q == CW'(w_c - 1'b1));
  assign vval0 = act && (trow_q >= TRW'(r_c)) && (trow_q < TRW'(h_c) + TRW'(r_c));
  assign vrow0 = RowW'(trow_q - TRW'(r_c));
  assign lr_we = is_pix && (obs || (trow_q == '0));
  assign pxf0  = is_pix && (rp_q == wp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick0_q     <= 1'b1;
      frame_rcv_q <= 1'b0;
      w_q         <= '0;
      h_q         <= '0;
      r_q         <= '0;
      tcol_q      <= '0;
      trow_q      <= '0;
      ocol_q      <= '0;
      orow_q      <= '0;
      wait_q      <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
    end else if (act) begin
      if (tick0_q) begin
        w_q     <= w_cfg;
        h_q     <= h_cfg;
        r_q     <= r_cfg;
        tick0_q <= 1'b0;
      end
      if (tcol_q == CW'(w_c - 1'b1)) begin
        tcol_q <= '0;
        trow_q <= trow_q + 1'b1;
      end else begin
        tcol_q <= tcol_q + 1'b1;
      end
      if (is_pix && (tcol_q == CW'(w_c - 1'b1)) && (trow_q == TRW'(h_c - 1'b1))) begin
        frame_rcv_q <= 1'b1;
      end
      if (is_pix) begin
        wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      end
      wait_q <= (wait_c == '0) ? '0 : wait_c - 1'b1;
      if (emit0) begin
        rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
        if (ocol_q == CW'(w_c - 1'b1)) begin
          ocol_q <= '0;
          orow_q <= orow_q + 1'b1;
        end else begin
          ocol_q <= ocol_q + 1'b1;
        end
      end
      if (fin0) begin
        tick0_q     <= 1'b1;
        frame_rcv_q <= 1'b0;
        tcol_q      <= '0;
        trow_q      <= '0;
        ocol_q      <= '0;
        orow_q      <= '0;
        wp_q        <= '0;
        rp_q        <= '0;
      end
    end
  end

  // memories
  logic [LW-1:0]   lr_mem [MAX_WIDTH];
  logic [LW-1:0]   lr_rd_q;
  logic [PixW-1:0] px_mem [Depth];
  logic [PixW-1:0] px_rd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (lr_we) begin
        lr_mem[tcol_q] <= {obs, RowW'(trow_q)};
      end
      lr_rd_q <= lr_mem[tcol_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (is_pix) begin
        px_mem[wp_q] <= s_axis_tdata;
      end
      px_rd_q <= px_mem[rp_q];
    end
  end

  // stage 1: vertical mark
  logic            act1_q, vval1_q, emit1_q, lrf1_q, pxf1_q, fin1_q;
  logic [LW-1:0]   lrd1_q, lr1;
  logic [RowW-1:0] vrow1_q;
  logic [RW-1:0]   r1_q;
  logic [WW-1:0]   w1_q;
  logic [CW-1:0]   m1_q;
  logic [PixW-1:0] px1_q;
  logic            vmark1;
  logic [SRW-1:0]  sr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act1_q  <= 1'b0;
      vval1_q <= 1'b0;
      emit1_q <= 1'b0;
    end else if (en) begin
      act1_q  <= act;
      vval1_q <= vval0;
      emit1_q <= emit0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lrf1_q  <= lr_we;
      lrd1_q  <= {obs, RowW'(trow_q)};
      vrow1_q <= vrow0;
      r1_q    <= r_c;
      w1_q    <= w_c;
      m1_q    <= ocol_q;
      fin1_q  <= fin0;
      pxf1_q  <= pxf0;
      px1_q   <= s_axis_tdata;
    end
  end

  assign lr1    = lrf1_q ? lrd1_q : lr_rd_q;
  assign vmark1 = vval1_q && lr1[LW-1] &&
                  ((LW'(lr1[RowW-1:0]) + LW'(r1_q)) > LW'(vrow1_q));

  always_ff @(posedge clk_i) begin
    if (en && act1_q) begin
      sr_q <= {sr_q[SRW-2:0], vmark1};
    end
  end

  // stage 2: horizontal window
  logic            emit2_q, fin2_q, mark2;
  logic [RW-1:0]   r2_q;
  logic [WW-1:0]   w2_q;
  logic [CW-1:0]   m2_q;
  logic [PixW-1:0] px2_q;
  logic [EW-1:0]   s2, lo2, hi2, two_r2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit2_q <= 1'b0;
    end else if (en) begin
      emit2_q <= emit1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin2_q <= fin1_q;
      r2_q   <= r1_q;
      w2_q   <= w1_q;
      m2_q   <= m1_q;
      px2_q  <= pxf1_q ? px1_q : px_rd_q;
    end
  end

  assign hi2    = EW'(m2_q) + EW'(r2_q);
  assign s2     = hi2 + 1'b1;
  assign lo2    = (s2 > EW'(w2_q)) ? s2 - EW'(w2_q) : '0;
  assign two_r2 = EW'(r2_q) << 1;

  always_comb begin
    mark2 = 1'b0;
    for (int j = 0; j < SRW; j++) begin
      if (sr_q[j] && (EW'(j) >= lo2) && (EW'(j) <= hi2) && (EW'(j) < two_r2)) begin
        mark2 = 1'b1;
      end
    end
  end

  // output register
  logic [PixW-1:0] out_data_q;
  logic            out_mark_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= emit2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && emit2_q) begin
      out_data_q <= mark2 ? {px2_q[31:24], 24'h0} : px2_q;
      out_mark_q <= mark2;
      out_last_q <= fin2_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_mark_q;
  assign m_axis_tlast  = out_last_q;

  // checks
  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin0 |=> tick0_q && !frame_rcv_q)
    else $error("frame end did not return to frame start");

  a_pixel_fwd_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit0 && pxf0 |-> r_c == '0)
    else $error("pixel read meets write with nonzero radius");

  a_input_pos_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick0_q && !frame_rcv_q |-> (tcol_q < CW'(w_q - 1'b1) || tcol_q == CW'(w_q - 1'b1))
      && trow_q < TRW'(h_q))
    else $error("input position outside latched map");

endmodule

>>> sim/testbench.sv
// testbench: self-checking stimulus for obstacle_map_dilation with a transfer-level predictor
// depends on omd_pkg and the obstacle_map_dilation rtl
// directed frames cover extremes and the special cases, then random small frames
module testbench import omd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BufDepth = (MaxWidthDef + 1) * (MaxRadiusDef + 1);
  localparam int unsigned CycleLimit = 600000;

  typedef struct packed {
    logic        flush;
    logic [31:0] pix;
  } pix_item_t;

  typedef struct packed {
    logic        marked;
    logic [31:0] pix;
    logic        last;
  } cell_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [PixW-1:0]     s_axis_tdata = '0;   // red_in, green_in, blue_in, alpha_in
  logic                s_axis_tuser = 1'b0; // action
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [PixW-1:0]     m_axis_tdata;        // red_out, green_out, blue_out, alpha_out
  logic                m_axis_tuser;        // marked
  logic                m_axis_tlast;        // last

  obstacle_map_dilation dut (.*);

  always #1 clk_i = ~clk_i;

  pix_item_t   pending_q[$];
  cell_t       cell_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        s_taken = 1'b0;

  // predictor state
  int unsigned reg_w = ResetWidth, reg_h = ResetHeight, reg_r = ResetRadius;
  int unsigned geo_w = ResetWidth, geo_h = ResetHeight, geo_r = ResetRadius;
  int unsigned in_row, in_col, out_row, out_col, tick;
  bit          frame_done;
  int unsigned obst_row[MaxWidthDef];
  bit          col_seen[MaxWidthDef];
  bit          mark_mem[BufDepth];
  logic [31:0] pix_mem[BufDepth];

  task automatic predict_cell(input logic flush, input logic [31:0] px);
    int unsigned n, rd, dl, v, k, c, q, base, lo, hi;
    bit mk, fin;
    cell_t e;
    if (!flush && !frame_done) begin
      if (tick == 0) begin
        geo_w = reg_w == 0 ? 1 : (reg_w > MaxWidthDef ? MaxWidthDef : reg_w);
        geo_h = reg_h == 0 ? 1 : (reg_h > MaxHeight ? MaxHeight : reg_h);
        geo_r = reg_r > MaxRadiusDef ? MaxRadiusDef : reg_r;
      end
      pix_mem[tick % BufDepth] = px;
      if (px[23:0] == 24'd0) begin
        obst_row[in_col] = in_row;
        col_seen[in_col] = 1'b1;
      end
      in_col++;
      if (in_col >= geo_w) begin
        in_col = 0;
        in_row++;
        if (in_row >= geo_h) begin
          in_row = 0;
          frame_done = 1'b1;
        end
      end
    end else if (!frame_done) begin
      return;
    end
    n  = geo_w * geo_h;
    rd = geo_r * geo_w;
    dl = rd + geo_r;
    if (tick >= rd) begin
      v = tick - rd;
      if (v < n) begin
        k = v / geo_w;
        c = v % geo_w;
        mark_mem[v % BufDepth] = col_seen[c] && (obst_row[c] + geo_r > k);
      end
    end
    if (tick >= dl) begin
      q    = tick - dl;
      base = q - out_col;
      lo   = (out_col + 1 >= geo_r) ? out_col + 1 - geo_r : 0;
      hi   = (out_col + geo_r < geo_w) ? out_col + geo_r : geo_w - 1;
      mk   = 1'b0;
      fin  = (q + 1 == n);
      for (c = lo; c <= hi; c++)
        if (mark_mem[(base + c) % BufDepth]) mk = 1'b1;
      e.marked = mk;
      e.pix    = pix_mem[q % BufDepth];
      if (mk) e.pix[23:0] = 24'd0;
      e.last   = fin;
      cell_q.push_back(e);
      if (fin) begin
        tick = 0; in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        frame_done = 1'b0;
        foreach (col_seen[i]) col_seen[i] = 1'b0;
      end else begin
        out_col++;
        if (out_col >= geo_w) begin
          out_col = 0;
          out_row++;
        end
        tick++;
      end
      return;
    end
    tick++;
  endtask

  // driver
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (!s_axis_tvalid || s_taken) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_q[0].flush;
        s_axis_tdata  <= pending_q[0].pix;
        void'(pending_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and predictor update
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("obstacle_map_dilation: mismatch");
      $finish;
    end else begin
      s_taken <= s_axis_tvalid && s_axis_tready;
      if (rst_ni && cfg_we_i) begin
        case (cfg_idx_i)
          RegMapWidth:  reg_w = cfg_data_i[CfgWidthW-1:0];
          RegMapHeight: reg_h = cfg_data_i[CfgHeightW-1:0];
          RegRadius:    reg_r = cfg_data_i[CfgRadiusW-1:0];
          default: ;
        endcase
      end
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (cell_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result transfer %h", m_axis_tdata);
        end else if (cell_q[0] != {m_axis_tuser, m_axis_tdata, m_axis_tlast}) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("cell mismatch: exp marked=%b data=%h last=%b got marked=%b data=%h last=%b",
                     cell_q[0].marked, cell_q[0].pix, cell_q[0].last,
                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
          void'(cell_q.pop_front());
        end else begin
          void'(cell_q.pop_front());
        end
      end
      if (rst_ni && s_axis_tvalid && s_axis_tready) predict_cell(s_axis_tuser, s_axis_tdata);
    end
  end

  task automatic wait_drained();
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    while (s_axis_tvalid || cell_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [31:0] rand_pixel(input int unsigned obst_pct);
    logic [31:0] px;
    px = $urandom;
    if ($urandom_range(99) < obst_pct) px[23:0] = 24'd0;
    else if ($urandom_range(9) == 0) px[8 * $urandom_range(2) +: 8] = 8'd0;
    return px;
  endfunction

  // pushes a whole frame plus its drain, returns the number of items that count
  function automatic int unsigned push_frame(input int unsigned w, input int unsigned h,
                                             input int unsigned r, input int unsigned pct);
    int unsigned ew, eh, er, cnt;
    pix_item_t it;
    ew = w == 0 ? 1 : (w > MaxWidthDef ? MaxWidthDef : w);
    eh = h == 0 ? 1 : (h > MaxHeight ? MaxHeight : h);
    er = r > MaxRadiusDef ? MaxRadiusDef : r;
    cnt = 0;
    for (int unsigned i = 0; i < ew * eh; i++) begin
      if ($urandom_range(19) == 0) begin
        it.flush = 1'b1; it.pix = $urandom;  // ignored mid-frame
        pending_q.push_back(it);
      end
      it.flush = 1'b0; it.pix = rand_pixel(pct);
      pending_q.push_back(it);
      cnt++;
    end
    for (int unsigned i = 0; i < er * ew + er; i++) begin
      it.flush = ($urandom_range(9) < 7); it.pix = $urandom;
      pending_q.push_back(it);
      cnt++;
    end
    return cnt;
  endfunction

  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned r);
    wait_drained();
    write_reg(RegMapWidth, w);
    write_reg(RegMapHeight, h);
    write_reg(RegRadius, r);
  endtask

  initial begin
    int unsigned rand_items, w, h, r, unused;
    pix_item_t it;
    send_idle_pct = 35;
    recv_idle_pct = 61;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry is too large to run, so start with a tiny map
    set_geometry(3, 3, 1);
    it.flush = 1'b1; it.pix = 32'hffff_ffff;
    pending_q.push_back(it);  // flush before any pixel is ignored
    unused = push_frame(3, 3, 1, 40);
    unused = push_frame(3, 3, 1, 100);
    unused = push_frame(3, 3, 1, 0);
    set_geometry(4, 3, 0);
    unused = push_frame(4, 3, 0, 50);
    set_geometry(0, 0, 31);     // out of range values clamp
    unused = push_frame(0, 0, 31, 100);
    set_geometry(1, 40, 16);
    unused = push_frame(1, 40, 16, 10);
    set_geometry(5, 4, 2);
    unused = push_frame(5, 4, 2, 15);

    // register change in the middle of a frame takes effect with the next frame
    set_geometry(3, 2, 1);
    for (int i = 0; i < 3; i++) begin
      it.flush = 1'b0; it.pix = rand_pixel(50);
      pending_q.push_back(it);
    end
    wait_drained();
    write_reg(RegMapWidth, 5);
    write_reg(RegRadius, 0);
    for (int i = 0; i < 3; i++) begin
      it.flush = 1'b0; it.pix = rand_pixel(50);
      pending_q.push_back(it);
    end
    for (int i = 0; i < 4; i++) begin
      it.flush = 1'b1; it.pix = $urandom;
      pending_q.push_back(it);
    end
    unused = push_frame(5, 2, 0, 50);

    rand_items = 0;
    w = 5; h = 2; r = 0;
    while (rand_items < 540) begin
      if (rand_items >= 360) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end else if (rand_items >= 180) begin
        send_idle_pct = 61; recv_idle_pct = 35;
      end
      if ($urandom_range(3) == 0) begin
        w = ($urandom_range(7) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
        h = $urandom_range(1, 5);
        if ($urandom_range(5) == 0) begin
          w = $urandom_range(1, 3);
          r = $urandom_range(4, 16);
        end else begin
          r = $urandom_range(0, 3);
        end
        set_geometry(w, h, r);
      end
      rand_items += push_frame(w, h, r, $urandom_range(5, 40));
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) $display("obstacle_map_dilation: match");
    else $display("obstacle_map_dilation: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/omd_pkg.sv
hw/rtl/obstacle_map_dilation.sv
sim/testbench.sv
